// ----- hdl/rmj_pkg.sv -----
// ----------------------------------------------------------------------------
// Radar measurement Jacobian package
// Shared widths, flag group and the Q16.16 saturation helper.
// ----------------------------------------------------------------------------
package rmj_pkg;

    localparam int DATA_W  = 32;
    localparam int CFG_W   = 32;
    localparam logic [CFG_W-1:0] MIN_RANGE_SQ_RESET = 32'd429497;

    // Square root of the 64-bit squared range gives a 32-bit root.
    localparam int SQ_W    = 64;
    localparam int ROOT_W  = 32;

    // Dividers: position over range, position over squared range, rate term.
    localparam int DIVR_NUM_W = 48;
    localparam int DIVR_QB    = 17;
    localparam int DIVC_NUM_W = 64;
    localparam int DIVC_QB    = 32;
    localparam int PROD_W     = 96;
    localparam int DIVT_NUM_W = 112;
    localparam int DIVT_QB    = 32;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic tneg;
        logic degen;
    } rmj_flags_t;

    function automatic logic [DATA_W-1:0] sat_q16(input logic neg, input logic ovf,
                                                  input logic [DATA_W-1:0] mag);
        logic [DATA_W-1:0] limit;
        logic [DATA_W-1:0] m;
        limit = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        m = (ovf || (mag > limit)) ? limit : mag;
        return neg ? (32'd0 - m) : m;
    endfunction

endpackage

// ----- hdl/radar_measurement_jacobian.sv -----
// ----------------------------------------------------------------------------
// Radar measurement Jacobian
// Six distinct entries of the range / bearing / range-rate Jacobian of a
// Q16.16 track state, with a degenerate flag for short range.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one state item: position x, y and velocity x, y (Q16.16).
//   m_* returns one result item per state item, in order: the six Jacobian
//   entries in m_tdata and the degenerate flag in m_tuser.
//   cfg_* writes the squared range threshold (Q32.32); it is always ready
//   and should be written only while no item is in flight.
//   From acceptance to m_tvalid an item passes five front stages (magnitudes,
//   squares and cross products, sums, partial products, rate numerators), a
//   32-stage square root, the range-cube product and a 33-stage divider for
//   the rate terms. One item is accepted every cycle unless the output stalls.
//   Reset clears all valid bits and loads the threshold reset value.
//   When the receiver stalls, the result waits in the output register and
//   the pipeline keeps moving until the next result reaches its last stage;
//   only then is s_tready taken low. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module radar_measurement_jacobian (
    input  logic         aclk,
    input  logic         aresetn,
    // cfg_data: min_range_squared
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data,
    // s_tdata: position_x, position_y, velocity_x, velocity_y
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,
    // m_tdata: d_range_d_px, d_range_d_py, d_bearing_d_px, d_bearing_d_py,
    //          d_rate_d_px, d_rate_d_py
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,
    // m_tuser: degenerate
    output logic [0:0]   m_tuser
);

    localparam int SQ_STEPS   = rmj_pkg::ROOT_W;
    localparam int FRONT      = 5;
    localparam int P_ROOT     = SQ_STEPS;
    localparam int P_DPROD    = P_ROOT + 2;
    localparam int P_DIVC_OUT = rmj_pkg::DIVC_QB + 1;
    localparam int P_DIVR_OUT = P_ROOT + rmj_pkg::DIVR_QB + 1;
    localparam int P_TAIL     = P_DPROD + rmj_pkg::DIVT_QB + 1;
    localparam int NSTAGE     = FRONT + P_TAIL;
    localparam int FLAG_DLY   = P_TAIL;
    localparam int MAG_DLY    = P_ROOT;
    localparam int NUM_DLY    = P_DPROD;
    localparam int DIVC_DLY   = P_TAIL - P_DIVC_OUT;
    localparam int DIVR_DLY   = P_TAIL - P_DIVR_OUT;

    // Configuration register
    logic [31:0] min_range_sq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_range_sq_reg <= rmj_pkg::MIN_RANGE_SQ_RESET;
        end else if (cfg_valid) begin
            min_range_sq_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    // Flow control
    logic              out_free;
    logic              en;
    logic [NSTAGE-1:0] vld_reg;

    assign out_free = !m_tvalid || m_tready;
    assign en       = !vld_reg[NSTAGE-1] || out_free;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTAGE-2:0], s_tvalid};
        end
    end

    // Stage 1: magnitudes and signs
    logic [31:0] px_in, py_in, vx_in, vy_in;
    logic [31:0] st1_px_reg, st1_py_reg, st1_vx_reg, st1_vy_reg;
    logic [31:0] st1_apx_reg, st1_apy_reg;

    assign px_in = s_tdata[31:0];
    assign py_in = s_tdata[63:32];
    assign vx_in = s_tdata[95:64];
    assign vy_in = s_tdata[127:96];

    always_ff @(posedge aclk) begin
        if (en) begin
            st1_px_reg  <= px_in;
            st1_py_reg  <= py_in;
            st1_vx_reg  <= vx_in;
            st1_vy_reg  <= vy_in;
            st1_apx_reg <= px_in[31] ? (32'd0 - px_in) : px_in;
            st1_apy_reg <= py_in[31] ? (32'd0 - py_in) : py_in;
        end
    end

    // Stage 2: squares and cross products
    logic [63:0]        sqx_next, sqy_next;
    logic signed [63:0] a_next, b_next;
    logic [63:0]        st2_sqx_reg, st2_sqy_reg;
    logic signed [63:0] st2_a_reg, st2_b_reg;
    logic [31:0]        st2_apx_reg, st2_apy_reg;
    logic               st2_nx_reg, st2_ny_reg;

    assign sqx_next = st1_apx_reg * st1_apx_reg;
    assign sqy_next = st1_apy_reg * st1_apy_reg;
    assign a_next   = $signed(st1_vx_reg) * $signed(st1_py_reg);
    assign b_next   = $signed(st1_vy_reg) * $signed(st1_px_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            st2_sqx_reg <= sqx_next;
            st2_sqy_reg <= sqy_next;
            st2_a_reg   <= a_next;
            st2_b_reg   <= b_next;
            st2_apx_reg <= st1_apx_reg;
            st2_apy_reg <= st1_apy_reg;
            st2_nx_reg  <= st1_px_reg[31];
            st2_ny_reg  <= st1_py_reg[31];
        end
    end

    // Stage 3: squared range and the cross term as sign and magnitude
    logic [63:0] c_next;
    logic [64:0] diff_next, diff_neg;
    logic [63:0] st3_c_reg, st3_tmag_reg;
    logic [31:0] st3_apx_reg, st3_apy_reg;
    logic        st3_nx_reg, st3_ny_reg, st3_tneg_reg;

    assign c_next    = st2_sqx_reg + st2_sqy_reg;
    assign diff_next = {st2_a_reg[63], st2_a_reg} - {st2_b_reg[63], st2_b_reg};
    assign diff_neg  = 65'd0 - diff_next;

    always_ff @(posedge aclk) begin
        if (en) begin
            st3_c_reg    <= c_next;
            st3_tneg_reg <= diff_next[64];
            st3_tmag_reg <= diff_next[64] ? diff_neg[63:0] : diff_next[63:0];
            st3_apx_reg  <= st2_apx_reg;
            st3_apy_reg  <= st2_apy_reg;
            st3_nx_reg   <= st2_nx_reg;
            st3_ny_reg   <= st2_ny_reg;
        end
    end

    // Stage 4: threshold test and partial products of the rate numerators
    logic [63:0]         st4_c_reg;
    logic [63:0]         st4_px_lo_reg, st4_px_hi_reg, st4_py_lo_reg, st4_py_hi_reg;
    logic [31:0]         st4_apx_reg, st4_apy_reg;
    rmj_pkg::rmj_flags_t st4_flags_reg;
    logic [63:0]         px_lo_next, px_hi_next, py_lo_next, py_hi_next;

    assign px_lo_next = st3_apx_reg * st3_tmag_reg[31:0];
    assign px_hi_next = st3_apx_reg * st3_tmag_reg[63:32];
    assign py_lo_next = st3_apy_reg * st3_tmag_reg[31:0];
    assign py_hi_next = st3_apy_reg * st3_tmag_reg[63:32];

    always_ff @(posedge aclk) begin
        if (en) begin
            st4_c_reg           <= st3_c_reg;
            st4_px_lo_reg       <= px_lo_next;
            st4_px_hi_reg       <= px_hi_next;
            st4_py_lo_reg       <= py_lo_next;
            st4_py_hi_reg       <= py_hi_next;
            st4_apx_reg         <= st3_apx_reg;
            st4_apy_reg         <= st3_apy_reg;
            st4_flags_reg.neg_x <= st3_nx_reg;
            st4_flags_reg.neg_y <= st3_ny_reg;
            st4_flags_reg.tneg  <= st3_tneg_reg;
            // A zero range is degenerate even with a zero threshold.
            st4_flags_reg.degen <= (st3_c_reg == 64'd0) ||
                                   (st3_c_reg < {32'd0, min_range_sq_reg});
        end
    end

    // Stage 5: rate numerators without the Q16 scaling
    logic [95:0]         st5_nx_reg, st5_ny_reg;
    logic [63:0]         st5_c_reg;
    logic [31:0]         st5_apx_reg, st5_apy_reg;
    rmj_pkg::rmj_flags_t st5_flags_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            st5_nx_reg    <= 96'(st4_px_lo_reg) + {st4_px_hi_reg, 32'd0};
            st5_ny_reg    <= 96'(st4_py_lo_reg) + {st4_py_hi_reg, 32'd0};
            st5_c_reg     <= st4_c_reg;
            st5_apx_reg   <= st4_apx_reg;
            st5_apy_reg   <= st4_apy_reg;
            st5_flags_reg <= st4_flags_reg;
        end
    end

    // Square root, two radicand bits per stage
    logic [33:0] sq_rem_reg  [SQ_STEPS];
    logic [31:0] sq_root_reg [SQ_STEPS];
    logic [63:0] sq_c_reg    [SQ_STEPS];

    genvar i;
    generate
        for (i = 0; i < SQ_STEPS; i++) begin : g_sqrt
            localparam int M = SQ_STEPS - 1 - i;
            logic [63:0] c_in;
            logic [33:0] rem_in;
            logic [31:0] root_in;
            logic [35:0] acc;
            logic [35:0] trial;
            logic        take;

            if (i == 0) begin : g_first
                assign c_in    = st5_c_reg;
                assign rem_in  = '0;
                assign root_in = '0;
            end else begin : g_rest
                assign c_in    = sq_c_reg[i-1];
                assign rem_in  = sq_rem_reg[i-1];
                assign root_in = sq_root_reg[i-1];
            end

            assign acc   = {rem_in, c_in[2*M+1 -: 2]};
            assign trial = {2'b00, root_in, 2'b01};
            assign take  = acc >= trial;

            always_ff @(posedge aclk) begin
                if (en) begin
                    sq_rem_reg[i]  <= take ? 34'(acc - trial) : acc[33:0];
                    sq_root_reg[i] <= {root_in[30:0], take};
                    sq_c_reg[i]    <= c_in;
                end
            end
        end
    endgenerate

    // Side data delay lines
    rmj_pkg::rmj_flags_t flag_dly_reg [FLAG_DLY];
    logic [63:0]         mag_dly_reg  [MAG_DLY];
    logic [191:0]        num_dly_reg  [NUM_DLY];

    always_ff @(posedge aclk) begin
        if (en) begin
            flag_dly_reg[0] <= st5_flags_reg;
            mag_dly_reg[0]  <= {st5_apy_reg, st5_apx_reg};
            num_dly_reg[0]  <= {st5_ny_reg, st5_nx_reg};
            for (int k = 1; k < FLAG_DLY; k++) begin
                flag_dly_reg[k] <= flag_dly_reg[k-1];
            end
            for (int k = 1; k < MAG_DLY; k++) begin
                mag_dly_reg[k] <= mag_dly_reg[k-1];
            end
            for (int k = 1; k < NUM_DLY; k++) begin
                num_dly_reg[k] <= num_dly_reg[k-1];
            end
        end
    end

    // Position over squared range
    logic [31:0] cq_x, cq_y;
    logic        covf_x, covf_y;

    rmj_div_pipe #(
        .NUM_W(rmj_pkg::DIVC_NUM_W), .DEN_W(rmj_pkg::SQ_W), .QUO_W(rmj_pkg::DIVC_QB)
    ) u_divc_x (
        .aclk(aclk), .en(en), .num({st5_apx_reg, 32'd0}), .den(st5_c_reg),
        .quo(cq_x), .ovf(covf_x)
    );

    rmj_div_pipe #(
        .NUM_W(rmj_pkg::DIVC_NUM_W), .DEN_W(rmj_pkg::SQ_W), .QUO_W(rmj_pkg::DIVC_QB)
    ) u_divc_y (
        .aclk(aclk), .en(en), .num({st5_apy_reg, 32'd0}), .den(st5_c_reg),
        .quo(cq_y), .ovf(covf_y)
    );

    // Position over range
    logic [31:0] root;
    logic [63:0] c_at_root;
    logic [31:0] apx_at_root, apy_at_root;
    logic [16:0] rq_x, rq_y;
    logic        rovf_x, rovf_y;

    assign root        = sq_root_reg[SQ_STEPS-1];
    assign c_at_root   = sq_c_reg[SQ_STEPS-1];
    assign apx_at_root = mag_dly_reg[MAG_DLY-1][31:0];
    assign apy_at_root = mag_dly_reg[MAG_DLY-1][63:32];

    rmj_div_pipe #(
        .NUM_W(rmj_pkg::DIVR_NUM_W), .DEN_W(rmj_pkg::ROOT_W), .QUO_W(rmj_pkg::DIVR_QB)
    ) u_divr_x (
        .aclk(aclk), .en(en), .num({apx_at_root, 16'd0}), .den(root),
        .quo(rq_x), .ovf(rovf_x)
    );

    rmj_div_pipe #(
        .NUM_W(rmj_pkg::DIVR_NUM_W), .DEN_W(rmj_pkg::ROOT_W), .QUO_W(rmj_pkg::DIVR_QB)
    ) u_divr_y (
        .aclk(aclk), .en(en), .num({apy_at_root, 16'd0}), .den(root),
        .quo(rq_y), .ovf(rovf_y)
    );

    // Range cubed, C times r, in two partial products
    logic [63:0] dp_lo_reg, dp_hi_reg;
    logic [95:0] dprod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            dp_lo_reg <= c_at_root[31:0] * root;
            dp_hi_reg <= c_at_root[63:32] * root;
            dprod_reg <= 96'(dp_lo_reg) + {dp_hi_reg, 32'd0};
        end
    end

    // Rate terms: one truncating division by C*r equals the two in sequence.
    logic [95:0] nx_at_prod, ny_at_prod;
    logic [31:0] tq_x, tq_y;
    logic        tovf_x, tovf_y;

    assign nx_at_prod = num_dly_reg[NUM_DLY-1][95:0];
    assign ny_at_prod = num_dly_reg[NUM_DLY-1][191:96];

    rmj_div_pipe #(
        .NUM_W(rmj_pkg::DIVT_NUM_W), .DEN_W(rmj_pkg::PROD_W), .QUO_W(rmj_pkg::DIVT_QB)
    ) u_divt_x (
        .aclk(aclk), .en(en), .num({nx_at_prod, 16'd0}), .den(dprod_reg),
        .quo(tq_x), .ovf(tovf_x)
    );

    rmj_div_pipe #(
        .NUM_W(rmj_pkg::DIVT_NUM_W), .DEN_W(rmj_pkg::PROD_W), .QUO_W(rmj_pkg::DIVT_QB)
    ) u_divt_y (
        .aclk(aclk), .en(en), .num({ny_at_prod, 16'd0}), .den(dprod_reg),
        .quo(tq_y), .ovf(tovf_y)
    );

    // Align the earlier quotients with the rate terms
    logic [65:0] divc_dly_reg [DIVC_DLY];
    logic [35:0] divr_dly_reg [DIVR_DLY];

    always_ff @(posedge aclk) begin
        if (en) begin
            divc_dly_reg[0] <= {covf_y, cq_y, covf_x, cq_x};
            divr_dly_reg[0] <= {rovf_y, rq_y, rovf_x, rq_x};
            for (int k = 1; k < DIVC_DLY; k++) begin
                divc_dly_reg[k] <= divc_dly_reg[k-1];
            end
            for (int k = 1; k < DIVR_DLY; k++) begin
                divr_dly_reg[k] <= divr_dly_reg[k-1];
            end
        end
    end

    // Output formatting and register
    rmj_pkg::rmj_flags_t tail_flags;
    logic [65:0]         tail_c;
    logic [35:0]         tail_r;
    logic [191:0]        jac;
    logic [191:0]        m_tdata_reg;
    logic                m_tvalid_reg;
    logic [0:0]          m_tuser_reg;

    assign tail_flags = flag_dly_reg[FLAG_DLY-1];
    assign tail_c     = divc_dly_reg[DIVC_DLY-1];
    assign tail_r     = divr_dly_reg[DIVR_DLY-1];

    assign jac = {
        rmj_pkg::sat_q16(!(tail_flags.neg_x ^ tail_flags.tneg), tovf_x, tq_x),
        rmj_pkg::sat_q16(tail_flags.neg_y ^ tail_flags.tneg, tovf_y, tq_y),
        rmj_pkg::sat_q16(tail_flags.neg_x, tail_c[32], tail_c[31:0]),
        rmj_pkg::sat_q16(!tail_flags.neg_y, tail_c[65], tail_c[64:33]),
        rmj_pkg::sat_q16(tail_flags.neg_y, tail_r[35], 32'(tail_r[34:18])),
        rmj_pkg::sat_q16(tail_flags.neg_x, tail_r[17], 32'(tail_r[16:0]))
    };

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= vld_reg[NSTAGE-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            m_tdata_reg <= tail_flags.degen ? '0 : jac;
            m_tuser_reg <= tail_flags.degen;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    // A degenerate item carries an all-zero Jacobian.
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("degenerate result with non-zero entries");

    // The x position over range never exceeds one in magnitude.
    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |->
            (($signed(m_tdata[31:0]) <= 32'sd65536) &&
             ($signed(m_tdata[31:0]) >= -32'sd65536)))
        else $error("d_range_d_px out of unit range");

    // A finished item at the tail with a stalled output holds the input back.
    a_tail_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[NSTAGE-1] && m_tvalid && !m_tready) |-> !s_tready)
        else $error("pipeline advanced over a waiting item");

    // An item leaving the tail appears at the output.
    a_tail_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[NSTAGE-1] && s_tready) |=> m_tvalid)
        else $error("item lost between tail and output");

    // Nothing is presented straight after reset.
    a_reset_idle: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("output valid after reset");
`endif

endmodule

// ----- hdl/rmj_div_pipe.sv -----
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, an overflow flag when the quotient needs more
// than QUO_W bits. One item per enabled cycle.
// ----------------------------------------------------------------------------
module rmj_div_pipe #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 64,
    parameter int QUO_W = 32
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo,
    output logic             ovf
);

    localparam int W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [W-1:0]     rem_reg [QUO_W+1];
    logic [DEN_W-1:0] den_reg [QUO_W+1];
    logic [QUO_W-1:0] quo_reg [QUO_W+1];
    logic             ovf_reg [QUO_W+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= W'(num);
            den_reg[0] <= den;
            quo_reg[0] <= '0;
            ovf_reg[0] <= W'(num) >= (W'(den) << QUO_W);
        end
    end

    genvar j;
    generate
        for (j = 1; j <= QUO_W; j++) begin : g_step
            localparam int K = QUO_W - j;
            logic [W-1:0]     trial;
            logic             take;
            logic [W-1:0]     rem_next;
            logic [QUO_W-1:0] quo_next;

            assign trial    = W'(den_reg[j-1]) << K;
            assign take     = rem_reg[j-1] >= trial;
            assign rem_next = take ? (rem_reg[j-1] - trial) : rem_reg[j-1];
            assign quo_next = quo_reg[j-1] | (QUO_W'(take) << K);

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[j] <= rem_next;
                    den_reg[j] <= den_reg[j-1];
                    quo_reg[j] <= quo_next;
                    ovf_reg[j] <= ovf_reg[j-1];
                end
            end
        end
    endgenerate

    assign quo = quo_reg[QUO_W];
    assign ovf = ovf_reg[QUO_W];

endmodule

// ----- bench/radar_measurement_jacobian_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Radar measurement Jacobian testbench
// Drives track states into the block through the input stream and predicts
// each Jacobian item in exact wide arithmetic. Every result item is compared
// field by field with the oldest prediction. The run covers several threshold
// settings, random idling on both sides and a long output stall.
// ----------------------------------------------------------------------------
module radar_measurement_jacobian_tb;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int DRAIN_CYCLES = 100;

    typedef struct {
        logic [191:0] entries;
        logic         degen;
    } jacobian_t;

    class jacobian_scoreboard;
        jacobian_t   pending[$];
        logic [31:0] threshold;
        int          errors;

        function new();
            threshold = rmj_pkg::MIN_RANGE_SQ_RESET;
            errors    = 0;
        endfunction

        function automatic logic [63:0] isqrt(input logic [63:0] n);
            logic [63:0] res;
            logic [63:0] bit_w;
            res   = 0;
            bit_w = 64'd1 << 62;
            while (bit_w > n) bit_w = bit_w >> 2;
            while (bit_w != 0) begin
                if (n >= res + bit_w) begin
                    n   = n - (res + bit_w);
                    res = (res >> 1) + bit_w;
                end else begin
                    res = res >> 1;
                end
                bit_w = bit_w >> 2;
            end
            return res;
        endfunction

        function automatic logic [31:0] clamp_q16(input logic neg, input logic [127:0] mag);
            logic [127:0] limit;
            logic [31:0]  m;
            limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
            m = (mag > limit) ? limit[31:0] : mag[31:0];
            return neg ? (32'd0 - m) : m;
        endfunction

        function automatic jacobian_t jacobian_of(input logic [127:0] state);
            longint           px, py, vx, vy, a, b;
            logic [63:0]      apx, apy, c, r, tmag;
            logic signed [64:0] t;
            logic             tneg;
            logic [127:0]     w;
            jacobian_t        j;
            px = longint'($signed(state[31:0]));
            py = longint'($signed(state[63:32]));
            vx = longint'($signed(state[95:64]));
            vy = longint'($signed(state[127:96]));
            apx = (px < 0) ? -px : px;
            apy = (py < 0) ? -py : py;
            c = apx * apx + apy * apy;
            j.entries = '0;
            j.degen   = 1'b0;
            if (c == 0 || c < {32'd0, threshold}) begin
                j.degen = 1'b1;
                return j;
            end
            r = isqrt(c);
            j.entries[31:0]   = clamp_q16(px < 0, 128'((apx << 16) / r));
            j.entries[63:32]  = clamp_q16(py < 0, 128'((apy << 16) / r));
            j.entries[95:64]  = clamp_q16(py > 0, 128'((apy << 32) / c));
            j.entries[127:96] = clamp_q16(px < 0, 128'((apx << 32) / c));
            a = vx * py;
            b = vy * px;
            t = $signed({a[63], a}) - $signed({b[63], b});
            tneg = t < 0;
            tmag = tneg ? 64'(-t) : 64'(t);
            w = (128'(apy << 16) * 128'(tmag)) / 128'(c) / 128'(r);
            j.entries[159:128] = clamp_q16(w != 0 && ((py < 0) != tneg), w);
            w = (128'(apx << 16) * 128'(tmag)) / 128'(c) / 128'(r);
            j.entries[191:160] = clamp_q16(w != 0 && ((px < 0) == tneg), w);
            return j;
        endfunction

        function void note_state(input logic [127:0] state);
            pending.push_back(jacobian_of(state));
        endfunction

        task report(input string what, input logic [31:0] got, input logic [31:0] want);
            $display("mismatch %s: got %h expected %h", what, got, want);
            errors++;
        endtask

        task check_result(input logic [191:0] entries, input logic degen);
            jacobian_t want;
            string     names[6];
            names = '{"d_range_d_px", "d_range_d_py", "d_bearing_d_px",
                      "d_bearing_d_py", "d_rate_d_px", "d_rate_d_py"};
            if (pending.size() == 0) begin
                report("unexpected item", 32'd0, 32'd0);
                return;
            end
            want = pending.pop_front();
            for (int k = 0; k < 6; k++)
                if (entries[32*k +: 32] !== want.entries[32*k +: 32])
                    report(names[k], entries[32*k +: 32], want.entries[32*k +: 32]);
            if (degen !== want.degen)
                report("degenerate", {31'd0, degen}, {31'd0, want.degen});
        endtask
    endclass

    logic         aclk;
    logic         aresetn;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [31:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [191:0] m_tdata;
    logic [0:0]   m_tuser;

    jacobian_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    int cycles;

    radar_measurement_jacobian u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off while hold_left counts down.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor and watchdog; values sampled here are those before the edge.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end else if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_state(s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser[0]);
        end
    end

    task automatic wait_drained();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [31:0] value);
        s_tvalid  <= 1'b0;
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.threshold = value;
    endtask

    // Offers one state item and returns once it has been accepted.
    task automatic send_state(input logic [31:0] px, input logic [31:0] py,
                              input logic [31:0] vx, input logic [31:0] vy);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {vy, vx, py, px};
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [31:0] random_field();
        int mode;
        int k;
        logic [31:0] v;
        mode = $urandom_range(9);
        if (mode <= 3) return $urandom;
        if (mode <= 7) begin
            k = $urandom_range(24);
            v = $urandom_range((1 << k) - 1);
            return $urandom_range(1) ? -v : v;
        end
        if (mode == 8) return $urandom_range(3) - 1;
        case ($urandom_range(2))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            default: return 32'h0001_0000;
        endcase
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_state(random_field(), random_field(), random_field(), random_field());
    endtask

    initial begin
        sb = new();
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        hold_left = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed items under the reset threshold.
        send_state(0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
        send_state(655, 0, 32'h0001_0000, 0);
        send_state(656, 0, 32'h0001_0000, 0);
        send_state(0, 656, 0, 32'h0001_0000);
        send_state(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_state(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_state(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_state(32'h0001_0000, 0, 0, 32'h7FFF_FFFF);
        send_state(0, 32'hFFFF_0000, 32'h7FFF_FFFF, 0);
        send_state(700, -700, 32'h7FFF_FFFF, 32'h8000_0000);
        send_state(-32'd1000, 1000, 32'h8000_0000, 32'h8000_0000);
        send_state(32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 32'hFFFF_0000);

        // Zero threshold: only zero range is degenerate.
        write_threshold(32'd0);
        send_state(0, 0, 1, 1);
        send_state(1, 0, 32'h7FFF_FFFF, 32'h8000_0000);
        send_state(0, -32'd1, 32'h8000_0000, 32'h7FFF_FFFF);
        send_state(1, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);

        // Largest threshold.
        write_threshold(32'hFFFF_FFFF);
        send_state(32'h0001_0000, 0, 1, 1);
        send_state(32'h0000_FFFF, 0, 1, 1);
        send_state(0, 32'hFFFF_0000, 32'h8000_0000, 1);

        write_threshold(rmj_pkg::MIN_RANGE_SQ_RESET);
        send_random(320);

        // Output held off while the input keeps offering items.
        send_idle_pct = 52;
        write_threshold($urandom);
        hold_left = 400;
        send_idle_pct = 0;
        send_random(150);
        send_idle_pct = 52;
        send_random(170);

        recv_stall_pct = 52;
        send_idle_pct = 0;
        write_threshold(32'd0);
        send_random(160);
        s_tvalid <= 1'b0;
        wait_drained();
        send_random(160);

        send_idle_pct = 21;
        recv_stall_pct = 21;
        write_threshold($urandom_range(32'h00FF_FFFF));
        send_random(160);
        write_threshold(32'hFFFF_FFFF);
        send_random(160);

        s_tvalid <= 1'b0;
        wait_drained();
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
